// File: src/assert_macros.svh
// Assertion macros for the order matcher.
// Empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_RST(label, clk, prop)
`endif
`endif

// File: src/lom_pkg.sv
// Types and codes shared by the order matcher modules.
// No dependencies.
package lom_pkg;
    localparam int unsigned PRICE_W = 32;
    localparam int unsigned QTY_W   = 24;
    localparam int unsigned IDENT_W = 32;
    localparam int unsigned ARR_W   = 32;

    typedef enum logic [1:0] {
        OUT_MORE    = 2'd0,
        OUT_FILLED  = 2'd1,
        OUT_RESTED  = 2'd2,
        OUT_DROPPED = 2'd3
    } t_outcome;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FILL,
        ST_REST
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_clear;
        logic scan_step;
        logic fill;
        logic rest;
        logic emit_none;
        logic emit_more;
        logic emit_final;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic remaining_zero;
        logic fill_count_full;
        logic free_found;
        logic any_fill;
    } t_status;
endpackage

// File: src/lom_datapath.sv
// Datapath of the order matcher: book storage, scan, fill and rest logic.
// Depends on lom_pkg.
module lom_datapath #(
    parameter int unsigned BOOK_SLOTS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lom_pkg::t_cmd                i_cmd,
    output lom_pkg::t_status             o_status,
    input  logic                         i_order_side,
    input  logic [lom_pkg::PRICE_W-1:0]  i_limit_price,
    input  logic [lom_pkg::QTY_W-1:0]    i_order_quantity,
    input  logic [lom_pkg::IDENT_W-1:0]  i_order_ident,
    output logic                         o_valid,
    output logic                         o_has_fill,
    output logic [lom_pkg::IDENT_W-1:0]  o_fill_ident,
    output logic [lom_pkg::PRICE_W-1:0]  o_fill_price,
    output logic [lom_pkg::QTY_W-1:0]    o_fill_quantity,
    output logic [lom_pkg::QTY_W-1:0]    o_remaining_quantity,
    output logic [1:0]                   o_outcome,
    output logic                         o_last_result
);
    import lom_pkg::*;

    localparam int unsigned IW = (BOOK_SLOTS > 1) ? $clog2(BOOK_SLOTS) : 1;
    localparam int unsigned CW = $clog2(BOOK_SLOTS + 1);

    logic [BOOK_SLOTS-1:0] r_valid;
    logic                  mem_side  [BOOK_SLOTS];
    logic [PRICE_W-1:0]    mem_price [BOOK_SLOTS];
    logic [QTY_W-1:0]      mem_qty   [BOOK_SLOTS];
    logic [IDENT_W-1:0]    mem_ident [BOOK_SLOTS];
    logic [ARR_W-1:0]      mem_arr   [BOOK_SLOTS];

    logic [ARR_W-1:0]   r_arrival;
    logic               r_side;
    logic [PRICE_W-1:0] r_limit;
    logic [QTY_W-1:0]   r_rem;
    logic [IDENT_W-1:0] r_ident;
    logic [CW-1:0]      r_nfill;

    logic [CW-1:0]      r_idx;
    logic               r_rd_ok;
    logic [IW-1:0]      r_rd_idx;
    logic               r_rd_side;
    logic [PRICE_W-1:0] r_rd_price;
    logic [ARR_W-1:0]   r_rd_arr;
    logic               r_last_rd;

    logic               r_found;
    logic [IW-1:0]      r_best;
    logic [PRICE_W-1:0] r_best_price;
    logic [ARR_W-1:0]   r_best_age;
    logic               r_free_found;
    logic [IW-1:0]      r_free;

    logic [QTY_W-1:0]   r_bq;
    logic [IDENT_W-1:0] r_bident;

    logic               r_valid_o;
    logic               r_has_fill;
    logic [IDENT_W-1:0] r_fid;
    logic [PRICE_W-1:0] r_fprice;
    logic [QTY_W-1:0]   r_fqty;
    logic [QTY_W-1:0]   r_orem;
    logic [1:0]         r_outc;
    logic               r_last;

    logic [ARR_W-1:0]   rd_age;
    logic               elig, better;
    logic [QTY_W-1:0]   q;
    logic [QTY_W-1:0]   n_rem;
    logic               fin;

    assign rd_age = r_arrival - r_rd_arr;
    assign elig = r_rd_ok && r_valid[r_rd_idx] && (r_rd_side != r_side) &&
                  (r_side ? (r_rd_price >= r_limit) : (r_rd_price <= r_limit));
    always_comb begin
        if (!r_found) begin
            better = 1'b1;
        end else if (r_rd_price != r_best_price) begin
            better = r_side ? (r_rd_price > r_best_price) : (r_rd_price < r_best_price);
        end else begin
            better = rd_age > r_best_age;
        end
    end
    assign q = (r_rem < r_bq) ? r_rem : r_bq;
    assign n_rem = r_rem - q;
    assign fin = (n_rem == '0) || (r_nfill == CW'(BOOK_SLOTS - 1));

    // lowest free slot is tracked during each scan
    always_ff @(posedge i_clk) begin
        r_rd_idx  <= r_idx[IW-1:0];
        r_rd_side <= mem_side[r_idx[IW-1:0]];
        r_rd_price <= mem_price[r_idx[IW-1:0]];
        r_rd_arr  <= mem_arr[r_idx[IW-1:0]];
        r_bq      <= mem_qty[r_best];
        r_bident  <= mem_ident[r_best];
        if (i_cmd.fill) begin
            mem_qty[r_best] <= r_bq - q;
        end
        if (i_cmd.rest && r_free_found) begin
            mem_side[r_free]  <= r_side;
            mem_price[r_free] <= r_limit;
            mem_qty[r_free]   <= r_rem;
            mem_ident[r_free] <= r_ident;
            mem_arr[r_free]   <= r_arrival;
        end
        if (i_cmd.load) begin
            r_side  <= i_order_side;
            r_limit <= i_limit_price;
            r_rem   <= i_order_quantity;
            r_ident <= i_order_ident;
        end else if (i_cmd.fill) begin
            r_rem <= n_rem;
        end
        if (r_rd_ok && elig && better) begin
            r_best       <= r_rd_idx;
            r_best_price <= r_rd_price;
            r_best_age   <= rd_age;
        end
        if (r_rd_ok && !r_valid[r_rd_idx] && !r_free_found) begin
            r_free <= r_rd_idx;
        end else if (i_cmd.fill && fin && (r_bq == q) &&
                     (!r_free_found || (r_best < r_free))) begin
            r_free <= r_best;
        end
        if (i_cmd.fill) begin
            r_has_fill <= 1'b1;
            r_fid      <= r_bident;
            r_fprice   <= r_best_price;
            r_fqty     <= q;
            r_orem     <= n_rem;
            r_outc     <= (n_rem == '0) ? OUT_FILLED : OUT_MORE;
            r_last     <= n_rem == '0;
        end else if (i_cmd.emit_none) begin
            r_has_fill <= 1'b0;
            r_fid      <= '0;
            r_fprice   <= '0;
            r_fqty     <= '0;
            r_orem     <= r_rem;
            r_outc     <= (r_rem == '0) ? OUT_FILLED :
                          (r_free_found ? OUT_RESTED : OUT_DROPPED);
            r_last     <= 1'b1;
        end else if (i_cmd.emit_final) begin
            r_outc <= r_free_found ? OUT_RESTED : OUT_DROPPED;
            r_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_arrival    <= '0;
            r_idx        <= '0;
            r_rd_ok      <= 1'b0;
            r_last_rd    <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_nfill      <= '0;
            r_valid_o    <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_nfill <= '0;
            end
            if (i_cmd.scan_clear) begin
                r_idx        <= '0;
                r_rd_ok      <= 1'b0;
                r_last_rd    <= 1'b0;
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_ok   <= r_idx < CW'(BOOK_SLOTS);
                r_last_rd <= r_idx == CW'(BOOK_SLOTS - 1);
                if (r_idx < CW'(BOOK_SLOTS)) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_rd_ok && elig) begin
                    r_found <= 1'b1;
                end
                if (r_rd_ok && !r_valid[r_rd_idx]) begin
                    r_free_found <= 1'b1;
                end
            end
            if (i_cmd.fill) begin
                r_nfill <= r_nfill + 1'b1;
                if (r_bq == q) begin
                    r_valid[r_best] <= 1'b0;
                end
                if (fin && (r_bq == q)) begin
                    r_free_found <= 1'b1;
                end
            end
            if (i_cmd.rest && r_free_found) begin
                r_valid[r_free] <= 1'b1;
                r_arrival <= r_arrival + 1'b1;
            end
            r_valid_o <= (i_cmd.fill && (n_rem == '0)) || i_cmd.emit_more ||
                         i_cmd.emit_none || i_cmd.emit_final;
        end
    end

    assign o_status.scan_done       = r_rd_ok && r_last_rd;
    assign o_status.found           = r_found || (r_rd_ok && elig);
    assign o_status.remaining_zero  = r_rem == '0;
    assign o_status.fill_count_full = fin;
    assign o_status.free_found      = r_free_found;
    assign o_status.any_fill        = r_nfill != '0;

    assign o_valid              = r_valid_o;
    assign o_has_fill           = r_has_fill;
    assign o_fill_ident         = r_fid;
    assign o_fill_price         = r_fprice;
    assign o_fill_quantity      = r_fqty;
    assign o_remaining_quantity = r_orem;
    assign o_outcome            = r_outc;
    assign o_last_result        = r_last;
endmodule

// File: src/lom_controller.sv
// Sequencer of the order matcher: scan, fill, rest.
// Depends on lom_pkg.
module lom_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    output lom_pkg::t_cmd    o_cmd,
    input  lom_pkg::t_status i_status
);
    import lom_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = r_state != ST_IDLE;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.scan_clear = 1'b1;
                    n_state          = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_done) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!i_status.remaining_zero && i_status.found) begin
                    o_cmd.emit_more = i_status.any_fill;
                    n_state         = ST_FILL;
                end else begin
                    n_state = ST_REST;
                end
            end
            ST_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_status.fill_count_full) begin
                    n_state = ST_REST;
                end else begin
                    o_cmd.scan_clear = 1'b1;
                    n_state          = ST_SCAN;
                end
            end
            ST_REST: begin
                o_cmd.rest       = !i_status.remaining_zero;
                o_cmd.emit_none  = !i_status.any_fill;
                o_cmd.emit_final = i_status.any_fill && !i_status.remaining_zero;
                n_state          = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// File: src/limit_order_matcher_unit.sv
// Top level of the limit order matcher.
// Depends on lom_pkg, lom_controller, lom_datapath, assert_macros.svh.
//
// channel   ports                                 handshake
// order     i_order_*, i_limit_price              start && !busy
// result    o_has_fill .. o_last_result           o_valid strobe, one cycle
//
// A search reads every slot through one port, then the decide state follows.
// Each fill takes a search and then the fill state; a final search follows unless a fill ends it.
// A fill result leaves in the next fill cycle, else in the rest cycle or the cycle after it.
// Reset clears the slot valid bits at once; no clearing pass.
// Results cannot be stalled; busy holds off the next order.
`include "assert_macros.svh"
module limit_order_matcher_unit #(
    parameter int unsigned BOOK_SLOTS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_order_side,
    input  logic [lom_pkg::PRICE_W-1:0]  i_limit_price,
    input  logic [lom_pkg::QTY_W-1:0]    i_order_quantity,
    input  logic [lom_pkg::IDENT_W-1:0]  i_order_ident,
    output logic                         o_valid,
    output logic                         o_has_fill,
    output logic [lom_pkg::IDENT_W-1:0]  o_fill_ident,
    output logic [lom_pkg::PRICE_W-1:0]  o_fill_price,
    output logic [lom_pkg::QTY_W-1:0]    o_fill_quantity,
    output logic [lom_pkg::QTY_W-1:0]    o_remaining_quantity,
    output logic [1:0]                   o_outcome,
    output logic                         o_last_result
);
    import lom_pkg::*;

    t_cmd    cmd;
    t_status status;

    lom_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_cmd    (cmd),
        .i_status (status)
    );

    lom_datapath #(.BOOK_SLOTS(BOOK_SLOTS)) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_order_side         (i_order_side),
        .i_limit_price        (i_limit_price),
        .i_order_quantity     (i_order_quantity),
        .i_order_ident        (i_order_ident),
        .o_valid              (o_valid),
        .o_has_fill           (o_has_fill),
        .o_fill_ident         (o_fill_ident),
        .o_fill_price         (o_fill_price),
        .o_fill_quantity      (o_fill_quantity),
        .o_remaining_quantity (o_remaining_quantity),
        .o_outcome            (o_outcome),
        .o_last_result        (o_last_result)
    );

    `ASSERT_IMPL(a_more_busy, i_clk, i_rst_n, (o_valid && !o_last_result) |-> busy)
    `ASSERT_IMPL(a_fill_qty, i_clk, i_rst_n, (o_valid && o_has_fill) |-> (o_fill_quantity != '0))
    `ASSERT_RST(a_rst_idle, i_clk, !i_rst_n |=> !busy)
endmodule

// File: tb/sv/limit_order_matcher_unit_tb.sv
// Testbench for limit_order_matcher_unit: drives limit orders and checks every result.
// Holds its own order book model in a small scoreboard class; depends on lom_pkg and the RTL.
module limit_order_matcher_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lom_pkg::*;

    localparam int SLOTS = 64;

    typedef struct packed {
        logic             has_fill;
        logic [31:0]      ident;
        logic [31:0]      price;
        logic [23:0]      qty;
        logic [23:0]      remaining;
        logic [1:0]       outcome;
        logic             last;
    } t_fill;

    int mismatches = 0;

    task automatic report(input string what, input t_fill got, input t_fill want);
        mismatches++;
        $display("mismatch %s at %0t: got %h want %h", what, $realtime, got, want);
    endtask

    class t_book_scoreboard;
        bit          live[SLOTS];
        bit          side[SLOTS];
        bit [31:0]   price[SLOTS];
        bit [23:0]   qty[SLOTS];
        bit [31:0]   ident[SLOTS];
        bit [31:0]   arrival[SLOTS];
        bit [31:0]   arrival_ctr;
        t_fill       pending[$];

        function int best_match(bit s, bit [31:0] lim);
            int b = -1;
            bit better;
            for (int i = 0; i < SLOTS; i++) begin
                if (!live[i] || side[i] == s) continue;
                if (s == 0 ? price[i] > lim : price[i] < lim) continue;
                if (b < 0) begin
                    b = i;
                end else begin
                    if (price[i] != price[b])
                        better = s == 0 ? price[i] < price[b] : price[i] > price[b];
                    else
                        better = (arrival_ctr - arrival[i]) > (arrival_ctr - arrival[b]);
                    if (better) b = i;
                end
            end
            return b;
        endfunction

        function void note_order(bit s, bit [31:0] lim, bit [23:0] q, bit [31:0] id);
            bit [23:0] rem = q;
            bit [23:0] t;
            int n = 0;
            int b;
            int freeslot = -1;
            t_fill r;
            t_outcome oc;
            while (rem > 0 && n < SLOTS) begin
                b = best_match(s, lim);
                if (b < 0) break;
                t = rem < qty[b] ? rem : qty[b];
                rem -= t;
                qty[b] -= t;
                if (qty[b] == 0) live[b] = 0;
                r = '{1'b1, ident[b], price[b], t, rem, OUT_MORE, 1'b0};
                pending.push_back(r);
                n++;
            end
            if (rem == 0) begin
                oc = OUT_FILLED;
            end else begin
                for (int i = 0; i < SLOTS; i++)
                    if (!live[i]) begin
                        freeslot = i;
                        break;
                    end
                if (freeslot < 0) begin
                    oc = OUT_DROPPED;
                end else begin
                    live[freeslot] = 1;
                    side[freeslot] = s;
                    price[freeslot] = lim;
                    qty[freeslot] = rem;
                    ident[freeslot] = id;
                    arrival[freeslot] = arrival_ctr;
                    arrival_ctr++;
                    oc = OUT_RESTED;
                end
            end
            if (n == 0) pending.push_back('{1'b0, 32'd0, 32'd0, 24'd0, rem, OUT_MORE, 1'b0});
            r = pending.pop_back();
            r.outcome = oc;
            r.last = 1'b1;
            pending.push_back(r);
        endfunction

        task check_fill(t_fill got);
            t_fill want;
            if (pending.size() == 0) begin
                report("unexpected", got, '0);
                return;
            end
            want = pending.pop_front();
            if (got.has_fill !== want.has_fill) report("has_fill", got, want);
            if (got.ident !== want.ident) report("fill_ident", got, want);
            if (got.price !== want.price) report("fill_price", got, want);
            if (got.qty !== want.qty) report("fill_quantity", got, want);
            if (got.remaining !== want.remaining) report("remaining", got, want);
            if (got.outcome !== want.outcome) report("outcome", got, want);
            if (got.last !== want.last) report("last_result", got, want);
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic        i_order_side = 0;
    logic [31:0] i_limit_price = '0;
    logic [23:0] i_order_quantity = '0;
    logic [31:0] i_order_ident = '0;
    logic        o_valid, o_has_fill, o_last_result;
    logic [31:0] o_fill_ident, o_fill_price;
    logic [23:0] o_fill_quantity, o_remaining_quantity;
    logic [1:0]  o_outcome;

    t_book_scoreboard book = new();

    limit_order_matcher_unit #(.BOOK_SLOTS(SLOTS)) uut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            book.check_fill('{o_has_fill, o_fill_ident, o_fill_price, o_fill_quantity,
                              o_remaining_quantity, o_outcome, o_last_result});
    end

    int burst_left = 0;

    task automatic send_order(bit s, bit [31:0] lim, bit [23:0] q, bit [31:0] id);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if (gap != 0) begin
                start <= 0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        start <= 1;
        i_order_side <= s;
        i_limit_price <= lim;
        i_order_quantity <= q;
        i_order_ident <= id;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        book.note_order(s, lim, q, id);
    endtask

    task automatic random_order(int band);
        bit [31:0] base = 32'd1000;
        bit [31:0] lim;
        bit [23:0] q;
        case ($urandom_range(0, 9))
            0: lim = $urandom();
            1: lim = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            default: lim = base + $urandom_range(0, band);
        endcase
        case ($urandom_range(0, 9))
            0: q = 24'($urandom());
            1: q = 24'hFF_FFFF;
            2: q = 0;
            default: q = 24'($urandom_range(1, 40));
        endcase
        send_order(1'($urandom_range(0, 1)), lim, q, $urandom());
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        // directed: empty book, extremes, time priority, sweep
        send_order(0, 32'd0, 24'd0, 32'hFFFF_FFFF);
        send_order(0, 32'd100, 24'd5, 32'd1);
        send_order(0, 32'd100, 24'd7, 32'd2);
        send_order(0, 32'd101, 24'd3, 32'd3);
        send_order(1, 32'd100, 24'd10, 32'd4);
        send_order(1, 32'd0, 24'hFF_FFFF, 32'd5);
        send_order(0, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'hAAAA_5555);
        send_order(1, 32'hFFFF_FFFF, 24'd1, 32'h5555_AAAA);
        send_order(1, 32'hFFFF_FFFF, 24'd1, 32'd6);
        send_order(0, 32'd0, 24'd1, 32'd7);
        send_order(1, 32'd0, 24'hFF_FFFF, 32'd8);
        // fill the book to capacity, then overflow
        for (int i = 0; i < SLOTS + 2; i++)
            send_order(1, 32'd5000 + (i % 4), 24'(1 + (i % 3)), 32'd100 + i);
        send_order(0, 32'd5003, 24'd300, 32'd9);
        for (int i = 0; i < 92; i++)
            random_order(i < 46 ? 6 : 60);
        @(negedge i_clk);
        start <= 0;
        while (book.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && book.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

// File: limit_order_matcher_unit.f
+incdir+src
src/lom_pkg.sv
src/lom_datapath.sv
src/lom_controller.sv
src/limit_order_matcher_unit.sv
tb/sv/limit_order_matcher_unit_tb.sv
